/* sv/athist_pkg.sv */
// ----------------------------------------------------------------------------
// athist_pkg
// Shared types, sizes and the size-bucket classifier for the allocation
// trace size histogram.
// ----------------------------------------------------------------------------
package athist_pkg;

    localparam int NUM_BUCKETS     = 14;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int BIN_W           = 4;
    localparam int ADDR_W          = 64;
    localparam int SIZE_W          = 48;
    localparam int BYTES_W         = 64;
    localparam int FIELD_W         = 32;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 232;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    localparam logic [SIZE_W-1:0] BUCKET_LIMIT [0:NUM_BUCKETS-2] = '{
        48'd32, 48'd64, 48'd128, 48'd256, 48'd512, 48'd1024, 48'd4096,
        48'd16384, 48'd32768, 48'd65536, 48'd131072, 48'd262144, 48'd1048576
    };

    typedef struct packed {
        logic              inc_alloc;
        logic              inc_temp;
        logic [SIZE_W-1:0] bytes;
    } t_bin_upd;

    typedef struct packed {
        logic [FIELD_W-1:0] bin_temps;
        logic [BYTES_W-1:0] bin_bytes;
        logic [FIELD_W-1:0] bin_allocs;
        logic [FIELD_W-1:0] temp_total;
        logic [FIELD_W-1:0] leaked_count;
        logic [FIELD_W-1:0] total_allocs;
        logic               was_temporary;
        logic [BIN_W-1:0]   bucket_index;
    } t_result;

    // smallest bucket whose upper bound holds the size
    function automatic logic [BIN_W-1:0] size_bucket(input logic [SIZE_W-1:0] size);
        logic [BIN_W-1:0] res;
        res = BIN_W'(NUM_BUCKETS - 1);
        for (int b = NUM_BUCKETS - 2; b >= 0; b--) begin
            if (size <= BUCKET_LIMIT[b]) begin
                res = BIN_W'(b);
            end
        end
        return res;
    endfunction

endpackage

/* sv/athist_bin.sv */
// ----------------------------------------------------------------------------
// athist_bin
// Counters of one size bucket: allocation count, byte sum, temporary count.
// ----------------------------------------------------------------------------
module athist_bin
    import athist_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_bin_upd               i_upd,
    output logic [COUNT_WIDTH-1:0] o_allocs,
    output logic [BYTES_W-1:0]     o_bytes,
    output logic [COUNT_WIDTH-1:0] o_temps
);

    logic [COUNT_WIDTH-1:0] r_allocs, n_alloc_cnt;
    logic [BYTES_W-1:0]     r_bytes,  n_bytes;
    logic [COUNT_WIDTH-1:0] r_temps,  n_temps;

    always_comb begin
        n_alloc_cnt = r_allocs;
        n_bytes     = r_bytes;
        n_temps     = r_temps;
        if (i_upd.inc_alloc) begin
            n_alloc_cnt = r_allocs + COUNT_WIDTH'(1);
            n_bytes     = r_bytes + BYTES_W'(i_upd.bytes);
        end
        if (i_upd.inc_temp) begin
            n_temps = r_temps + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allocs <= '0;
            r_bytes  <= '0;
            r_temps  <= '0;
        end else begin
            r_allocs <= n_alloc_cnt;
            r_bytes  <= n_bytes;
            r_temps  <= n_temps;
        end
    end

    assign o_allocs = r_allocs;
    assign o_bytes  = r_bytes;
    assign o_temps  = r_temps;

endmodule

/* sv/alloc_trace_size_histogram_core.sv */
// ----------------------------------------------------------------------------
// alloc_trace_size_histogram_core
// Path: a beat accepted into the input register moves on to the result register
// once that register is empty or being taken; output back-pressure can hold it.
// Throughput: one beat per cycle unless the master side stalls; bucket compare
// and counter update share the single stage between input and result register.
// Reset: synchronous active low; clears all counters, per-bucket sums and the
// previous-allocation mark. No clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module alloc_trace_size_histogram_core
    import athist_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // alloc_address[63:0], size[111:64], read_bin[115:112], zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // operation[0]
    input  logic [0:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // bucket_index[3:0], was_temporary[4], total_allocs[36:5],
    // leaked_count[68:37], temp_total[100:69], bin_allocs[132:101],
    // bin_bytes[196:133], bin_temps[228:197], zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // input register
    logic              r_in_valid;
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [BIN_W-1:0]  r_bin;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    // state
    logic                   r_prev_valid;
    logic [ADDR_W-1:0]      r_prev_addr;
    logic [BIN_W-1:0]       r_prev_bucket;
    logic [COUNT_WIDTH-1:0] r_alloc_cnt, n_alloc_cnt;
    logic [COUNT_WIDTH-1:0] r_leak_cnt,  n_leak_cnt;
    logic [COUNT_WIDTH-1:0] r_temp_cnt,  n_temp_cnt;

    logic adv;
    logic is_free, is_alloc, is_temp;
    logic [BIN_W-1:0] bucket;

    t_bin_upd               upd      [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] bin_allocs [NUM_BUCKETS];
    logic [BYTES_W-1:0]     bin_bytes  [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] bin_temps  [NUM_BUCKETS];

    logic [BYTES_W-1:0] w_alloc, w_leak, w_temp, w_ba, w_bt;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    assign is_free  = (r_op == OP_RECORD) && (r_size[SIZE_W-1] || (r_size == '0));
    assign is_alloc = (r_op == OP_RECORD) && !is_free;
    assign is_temp  = is_free && r_prev_valid && (r_prev_addr == r_addr);
    assign bucket   = size_bucket(r_size);

    genvar k;
    generate
        for (k = 0; k < NUM_BUCKETS; k++) begin : g_bin
            assign upd[k].inc_alloc = adv && is_alloc && (bucket == BIN_W'(k));
            assign upd[k].inc_temp  = adv && is_temp && (r_prev_bucket == BIN_W'(k));
            assign upd[k].bytes     = r_size;

            athist_bin #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_bin (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_upd    (upd[k]),
                .o_allocs (bin_allocs[k]),
                .o_bytes  (bin_bytes[k]),
                .o_temps  (bin_temps[k])
            );
        end
    endgenerate

    always_comb begin
        n_alloc_cnt = r_alloc_cnt;
        n_leak_cnt  = r_leak_cnt;
        n_temp_cnt  = r_temp_cnt;
        if (is_alloc) begin
            n_alloc_cnt = r_alloc_cnt + COUNT_WIDTH'(1);
            n_leak_cnt  = r_leak_cnt + COUNT_WIDTH'(1);
        end
        if (is_free) begin
            n_leak_cnt = r_leak_cnt - COUNT_WIDTH'(1);
        end
        if (is_temp) begin
            n_temp_cnt = r_temp_cnt + COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        w_alloc = BYTES_W'(n_alloc_cnt);
        w_leak  = BYTES_W'(n_leak_cnt);
        w_temp  = BYTES_W'(n_temp_cnt);
        w_ba    = '0;
        w_bt    = '0;
        n_out   = '0;
        n_out.bucket_index  = is_alloc ? bucket : '0;
        n_out.was_temporary = is_temp;
        n_out.total_allocs  = w_alloc[FIELD_W-1:0];
        n_out.leaked_count  = w_leak[FIELD_W-1:0];
        n_out.temp_total    = w_temp[FIELD_W-1:0];
        if ((r_op == OP_READ) && (r_bin < BIN_W'(NUM_BUCKETS))) begin
            w_ba               = BYTES_W'(bin_allocs[r_bin]);
            w_bt               = BYTES_W'(bin_temps[r_bin]);
            n_out.bin_bytes    = bin_bytes[r_bin];
        end
        n_out.bin_allocs = w_ba[FIELD_W-1:0];
        n_out.bin_temps  = w_bt[FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_valid  <= 1'b0;
            r_prev_addr   <= '0;
            r_prev_bucket <= '0;
            r_alloc_cnt   <= '0;
            r_leak_cnt    <= '0;
            r_temp_cnt    <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_alloc_cnt <= n_alloc_cnt;
                r_leak_cnt  <= n_leak_cnt;
                r_temp_cnt  <= n_temp_cnt;
                if (is_alloc) begin
                    r_prev_valid  <= 1'b1;
                    r_prev_addr   <= r_addr;
                    r_prev_bucket <= bucket;
                end else if (is_free) begin
                    r_prev_valid  <= 1'b0;
                    r_prev_addr   <= '0;
                    r_prev_bucket <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_op   <= t_op'(i_s_axis_tuser[0]);
            r_addr <= i_s_axis_tdata[ADDR_W-1:0];
            r_size <= i_s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W];
            r_bin  <= i_s_axis_tdata[ADDR_W+SIZE_W+BIN_W-1:ADDR_W+SIZE_W];
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out);

`ifndef SYNTH
    a_alloc_marks_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_alloc) |=> r_prev_valid)
        else $error("allocation did not set previous mark");

    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_op == OP_READ)) |=> ($stable(r_alloc_cnt) && $stable(r_leak_cnt)
                                        && $stable(r_temp_cnt)))
        else $error("read changed counters");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advanced beat not in result register");

    a_temp_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.was_temporary) |-> (r_out.bucket_index == '0))
        else $error("temporary flag on non-free result");
`endif

endmodule
